// ----- hdl/fas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fas_pkg
// Shared types, widths and a helper function of the frame animation sequencer.
// ----------------------------------------------------------------------------
package fas_pkg;

  localparam int MaxFrames  = 64;
  localparam int CellBits   = 12;
  localparam int TimeBits   = 16;
  localparam int SlotW      = $clog2(MaxFrames);
  localparam int AccW       = TimeBits + 1;
  localparam int OpW        = 2;
  localparam int SlotFieldW = 6;
  localparam int FcW        = 7;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 7;

  typedef enum logic [OpW-1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpPlay  = 2'd2,
    OpStop  = 2'd3
  } op_e;

  localparam logic [CfgIdxW-1:0] CfgIdxLoop    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxReverse = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxFrames  = 2'd2;

  typedef struct packed {
    logic           loop_en;
    logic           reverse;
    logic [FcW-1:0] frame_count;
  } cfg_t;

  typedef struct packed {
    logic [CellBits-1:0] cell_idx;
    logic [TimeBits-1:0] delay;
  } frame_entry_t;

  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    frame_entry_t     data;
  } mem_wr_t;

  typedef struct packed {
    logic [SlotFieldW-1:0] slot;
    logic [CellBits-1:0]   cell_idx;
    logic                  running;
  } res_t;

  // last slot in use, frame count clamped to 1..MaxFrames
  function automatic logic [SlotW-1:0] last_slot(input logic [FcW-1:0] fc);
    logic [SlotW-1:0] r;
    if (fc == '0) begin
      r = '0;
    end else if (32'(fc) > MaxFrames) begin
      r = SlotW'(MaxFrames - 1);
    end else begin
      r = SlotW'(fc - FcW'(1));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/fas_frame_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fas_frame_mem
// Frame table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fas_frame_mem (
  input  wire logic                        clk_i,
  input  wire fas_pkg::mem_wr_t            wr_i,
  input  wire logic [fas_pkg::SlotW-1:0]   raddr_i,
  output      fas_pkg::frame_entry_t       rdata_o
);
  import fas_pkg::*;

  frame_entry_t mem [MaxFrames];
  frame_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/fas_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fas_ctrl
// Sequencer with a shared accumulate, compare and subtract unit that steps
// through frames one table read at a time.
// ----------------------------------------------------------------------------
module fas_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [fas_pkg::OpW-1:0]        op_i,
  input  wire logic [fas_pkg::TimeBits-1:0]   elapsed_i,
  input  wire logic [fas_pkg::SlotFieldW-1:0] slot_i,
  input  wire logic [fas_pkg::CellBits-1:0]   entry_cell_i,
  input  wire logic [fas_pkg::TimeBits-1:0]   entry_delay_i,
  input  wire fas_pkg::cfg_t                  cfg_i,
  output      fas_pkg::mem_wr_t               mem_wr_o,
  output      logic [fas_pkg::SlotW-1:0]      mem_raddr_o,
  input  wire fas_pkg::frame_entry_t          mem_rdata_i,
  output      logic                           res_valid_o,
  input  wire logic                           res_ready_i,
  output      fas_pkg::res_t                  res_o
);
  import fas_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFetch = 3'd1;
  localparam logic [2:0] StCmp   = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [SlotW-1:0] pos_q, pos_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic             play_q, play_d;
  logic [SlotW-1:0] last;
  logic [AccW-1:0]  dly;

  assign last = last_slot(cfg_i.frame_count);
  assign dly  = (mem_rdata_i.delay == '0) ? AccW'(1) : AccW'(mem_rdata_i.delay);

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    acc_d         = acc_q;
    play_d        = play_q;
    mem_wr_o.en   = 1'b0;
    mem_wr_o.addr = SlotW'(slot_i);
    mem_wr_o.data = '{cell_idx: entry_cell_i, delay: entry_delay_i};
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRead;
          unique case (op_e'(op_i))
            OpTick: begin
              if (play_q) begin
                pos_d   = (pos_q > last) ? last : pos_q;
                acc_d   = acc_q + AccW'(elapsed_i);
                state_d = StFetch;
              end
            end
            OpWrite: begin
              mem_wr_o.en = (32'(slot_i) < MaxFrames);
            end
            OpPlay: begin
              play_d = 1'b1;
              pos_d  = cfg_i.reverse ? last : '0;
            end
            OpStop: begin
              play_d = 1'b0;
              acc_d  = '0;
            end
          endcase
        end
      end
      StFetch: state_d = StCmp;
      StCmp: begin
        if (acc_q >= dly) begin
          acc_d   = acc_q - dly;
          state_d = StFetch;
          if (cfg_i.reverse) begin
            if (pos_q == '0) begin
              if (cfg_i.loop_en) begin
                pos_d = last;
              end else begin
                play_d  = 1'b0;
                acc_d   = '0;
                state_d = StRead;
              end
            end else begin
              pos_d = pos_q - SlotW'(1);
            end
          end else begin
            if (pos_q >= last) begin
              if (cfg_i.loop_en) begin
                pos_d = '0;
              end else begin
                pos_d   = last;
                play_d  = 1'b0;
                acc_d   = '0;
                state_d = StRead;
              end
            end else begin
              pos_d = pos_q + SlotW'(1);
            end
          end
        end else begin
          state_d = StRead;
        end
      end
      StRead: state_d = StOut;
      StOut: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      acc_q   <= '0;
      play_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      play_q  <= play_d;
    end
  end

  assign in_ready_o   = (state_q == StIdle);
  assign res_valid_o  = (state_q == StOut);
  assign mem_raddr_o  = pos_q;
  assign res_o.slot     = SlotFieldW'(pos_q);
  assign res_o.cell_idx = mem_rdata_i.cell_idx;
  assign res_o.running  = play_q;

endmodule
`default_nettype wire

// ----- hdl/frame_animation_sequencer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_animation_sequencer_unit
// Sprite frame animation timer with a loadable frame table.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_ready_o) takes one request: tick, write
//   frame entry, play or stop. every request gives exactly one response on
//   the output channel (out_valid_o / out_ready_i): current slot, its cell
//   index and the running flag.
//   config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0 is
//   loop enable, 1 reverse mode, 2 frame count. write it only while idle.
//   steps: write, play, stop and an idle tick go through the read and the
//   output state into the output register. a running tick first adds a
//   fetch and a compare state per compare, each one frame table read plus
//   one compare and subtract in the shared accumulator unit: k frames
//   advanced take k + 1 compares, or k when the last advance ends playback.
//   in_ready_o is low from accept until the response is loaded into the
//   output register; the next request is taken while that response waits.
//   a stalled receiver holds the response and blocks the next one.
//   reset: loop on, forward, one frame, slot 0, stopped, accumulator clear.
//   the frame table is not cleared; read slots only after writing them.
// ----------------------------------------------------------------------------
module frame_animation_sequencer_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [fas_pkg::OpW-1:0]        op_i,
  input  wire logic [fas_pkg::TimeBits-1:0]   elapsed_i,
  input  wire logic [fas_pkg::SlotFieldW-1:0] slot_i,
  input  wire logic [fas_pkg::CellBits-1:0]   entry_cell_i,
  input  wire logic [fas_pkg::TimeBits-1:0]   entry_delay_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [fas_pkg::SlotFieldW-1:0] current_slot_o,
  output      logic [fas_pkg::CellBits-1:0]   current_cell_o,
  output      logic                           running_o,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [fas_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [fas_pkg::CfgDataW-1:0]   cfg_data_i
);
  import fas_pkg::*;

  cfg_t         cfg_q;
  mem_wr_t      mem_wr;
  logic [SlotW-1:0] mem_raddr;
  frame_entry_t mem_rdata;
  logic         res_valid;
  logic         res_ready;
  res_t         res;
  logic         out_valid_q;
  res_t         out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_en     <= 1'b1;
      cfg_q.reverse     <= 1'b0;
      cfg_q.frame_count <= FcW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgIdxLoop:    cfg_q.loop_en     <= cfg_data_i[0];
        CfgIdxReverse: cfg_q.reverse     <= cfg_data_i[0];
        CfgIdxFrames:  cfg_q.frame_count <= FcW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  fas_frame_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fas_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .elapsed_i     (elapsed_i),
    .slot_i        (slot_i),
    .entry_cell_i  (entry_cell_i),
    .entry_delay_i (entry_delay_i),
    .cfg_i         (cfg_q),
    .mem_wr_o      (mem_wr),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign current_slot_o = out_q.slot;
  assign current_cell_o = out_q.cell_idx;
  assign running_o      = out_q.running;

endmodule
`default_nettype wire

// ----- hdl/fas_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fas_checker
// Port level checks of the frame animation sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fas_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [fas_pkg::SlotFieldW-1:0] current_slot_o,
  input wire logic [fas_pkg::CellBits-1:0]   current_cell_o,
  input wire logic                           running_o
);

  // stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_slot_o)
      && $stable(current_cell_o) && $stable(running_o))
    else $error("stalled response changed");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after request");

  // response never appears the cycle after a request
  a_resp_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("response too early");

  // a new response only comes while the block is busy
  a_resp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response without request");

endmodule

bind frame_animation_sequencer_unit fas_checker u_fas_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .current_slot_o (current_slot_o),
  .current_cell_o (current_cell_o),
  .running_o      (running_o)
);
`default_nettype wire
